// ----- rtl/salru_pkg.sv -----
// Shared constants and types of the set-associative tag directory with matrix LRU.
// No dependencies; every other file of the block but salru_ram imports this package.
`timescale 1ns / 1ps

package salru_pkg;

  // Field and register widths of the external ports
  localparam int ADDR_W     = 32;
  localparam int OFFSET_W   = 4;
  localparam int SETB_W     = 4;
  localparam int AWAYS_W    = 3;
  localparam int WAY_OUT_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Widest raw set index the set-bit count can select before wrapping
  localparam int IDX_W = (1 << SETB_W) - 1;

  // Defaults for the top-level parameters
  localparam int WAYS_DEF      = 4;
  localparam int SETS_DEF      = 256;
  localparam int ADDR_BITS_DEF = 32;

  // Register values after reset
  localparam logic [OFFSET_W-1:0] OFFSET_BITS_RST = OFFSET_W'(6);
  localparam logic [SETB_W-1:0]   IDX_BITS_RST    = SETB_W'(8);
  localparam logic [AWAYS_W-1:0]  ACTIVE_WAYS_RST = AWAYS_W'(4);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_IDX_BITS    = 2'd1,
    CFG_ACTIVE_WAYS = 2'd2
  } cfg_reg_t;

endpackage

// ----- rtl/salru_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; a read and a write to one address in a cycle return the old word.
`timescale 1ns / 1ps

module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/salru_split.sv -----
// Address split: input register plus set index and tag extraction.
// Depends on salru_pkg; wraps the set index modulo SETS.
`timescale 1ns / 1ps

module salru_split import salru_pkg::*; #(
  parameter int SETS      = SETS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     ld,
  input  logic [ADDR_W-1:0]                        address,
  input  logic [OFFSET_W-1:0]                      offset_bits,
  input  logic [SETB_W-1:0]                        idx_bits,
  output logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] set_idx,
  output logic [(ADDR_BITS < ADDR_W ? ADDR_BITS : ADDR_W)-1:0] tag
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int TAG_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int EXT_W = (SET_W > IDX_W) ? SET_W : IDX_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ((ADDR_W'(1) << ADDR_BITS) - ADDR_W'(1));

  logic [ADDR_W-1:0]   addr_m;
  logic [SETB_W:0]     tag_sh;
  logic [IDX_W:0]      idx_mask;
  logic [IDX_W-1:0]    idx_nxt;
  logic [TAG_W-1:0]    tag_nxt;
  logic [TAG_W-1:0]    tag_r;

  // Cut the address into raw set index and tag
  always_comb begin
    addr_m   = address & ADDR_MASK;
    tag_sh   = {1'b0, offset_bits} + {1'b0, idx_bits};
    idx_mask = ((IDX_W + 1)'(1) << idx_bits) - (IDX_W + 1)'(1);
    idx_nxt  = IDX_W'(addr_m >> offset_bits) & idx_mask[IDX_W-1:0];
    tag_nxt  = TAG_W'(addr_m >> tag_sh);
  end

  // Capture the tag of the incoming transaction
  always_ff @(posedge clk) begin
    if (ld) begin
      tag_r <= tag_nxt;
    end
  end

  assign tag = tag_r;

  generate
    if ((SETS & (SETS - 1)) == 0) begin : g_pow2
      logic [IDX_W-1:0] idx_r;
      logic [EXT_W-1:0] idx_ext;

      always_ff @(posedge clk) begin
        if (ld) begin
          idx_r <= idx_nxt;
        end
      end

      // Power-of-two set count: wrap by masking
      always_comb begin
        idx_ext = EXT_W'(idx_r) & EXT_W'(SETS - 1);
        set_idx = idx_ext[SET_W-1:0];
      end
    end else begin : g_recip
      localparam int Q_SH  = 16;
      localparam int RECIP = 65536 / SETS;

      logic [31:0]      prod;
      logic [IDX_W-1:0] quo_nxt;
      logic [IDX_W-1:0] idx_r;
      logic [IDX_W-1:0] quo_r;
      logic [31:0]      rem;

      // Estimate the quotient by a reciprocal product ahead of the register
      always_comb begin
        prod    = 32'(idx_nxt) * 32'(RECIP);
        quo_nxt = IDX_W'(prod >> Q_SH);
      end

      always_ff @(posedge clk) begin
        if (ld) begin
          idx_r <= idx_nxt;
          quo_r <= quo_nxt;
        end
      end

      // Remainder, corrected once since the estimate may be one short
      always_comb begin
        rem = 32'(idx_r) - 32'(quo_r) * 32'(SETS);
        if (rem >= 32'(SETS)) begin
          rem = rem - 32'(SETS);
        end
        set_idx = SET_W'(rem);
      end
    end
  endgenerate

endmodule

// ----- rtl/salru_lookup.sv -----
// Tag compare, victim choice and LRU matrix update for one set.
// Depends on salru_pkg; purely combinational.
`timescale 1ns / 1ps

module salru_lookup import salru_pkg::*; #(
  parameter int WAYS  = WAYS_DEF,
  parameter int TAG_W = ADDR_W
) (
  input  logic [AWAYS_W-1:0]                       active_ways,
  input  logic [TAG_W-1:0]                         tag,
  input  logic [WAYS-1:0][TAG_W:0]                 tag_words,
  input  logic [WAYS*WAYS-1:0]                     lru_word,
  output logic                                     hit,
  output logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] used_way,
  output logic [WAYS*WAYS-1:0]                     lru_nxt
);

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NW    = $clog2(WAYS + 1);
  localparam int CNT_W = $clog2(WAYS + 1);

  logic [NW-1:0]    n_eff;
  logic [WAYS-1:0]  act;
  logic [WAYS-1:0]  hit_vec;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] victim;

  // Clamp the associativity in use to 1..WAYS
  always_comb begin
    if (active_ways == '0) begin
      n_eff = NW'(1);
    end else if (32'(active_ways) > 32'(WAYS)) begin
      n_eff = NW'(WAYS);
    end else begin
      n_eff = NW'(active_ways);
    end
    for (int w = 0; w < WAYS; w++) begin
      act[w] = (32'(w) < 32'(n_eff));
    end
  end

  // Compare the tag against every valid active way; lowest match wins
  always_comb begin
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = act[w] && tag_words[w][TAG_W] && (tag_words[w][TAG_W-1:0] == tag);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
    end
    hit = |hit_vec;
  end

  // Victim: fewest ones in the row over active columns, lowest way on ties
  always_comb begin
    logic [CNT_W-1:0] cnt;
    logic [CNT_W:0]   best_cnt;
    logic [WAYS-1:0]  row;
    victim   = '0;
    best_cnt = (CNT_W + 1)'(WAYS + 1);
    for (int w = 0; w < WAYS; w++) begin
      row = lru_word[w*WAYS +: WAYS] & act;
      cnt = '0;
      for (int j = 0; j < WAYS; j++) begin
        cnt = cnt + CNT_W'(row[j]);
      end
      if (act[w] && ({1'b0, cnt} < best_cnt)) begin
        best_cnt = {1'b0, cnt};
        victim   = WAY_W'(w);
      end
    end
  end

  assign used_way = hit ? hit_way : victim;

  // Set the used way's row, then clear its column across active rows
  always_comb begin
    logic [WAYS-1:0] row;
    for (int w = 0; w < WAYS; w++) begin
      row = lru_word[w*WAYS +: WAYS];
      if (WAY_W'(w) == used_way) begin
        row = row | act;
      end
      if (act[w]) begin
        for (int j = 0; j < WAYS; j++) begin
          if (WAY_W'(j) == used_way) begin
            row[j] = 1'b0;
          end
        end
      end
      lru_nxt[w*WAYS +: WAYS] = row;
    end
  end

endmodule

// ----- rtl/set_assoc_cache_matrix_lru.sv -----
// Top level of the set-associative tag directory with matrix LRU replacement.
// Depends on salru_pkg, salru_ram, salru_split and salru_lookup.
`timescale 1ns / 1ps

// One address per cycle goes in while in_stall is low and one hit/way result per
// address comes out, in order: the accepting edge loads the input register, the
// tag and LRU memories are then read into their output registers, and the
// compare/replace result is loaded into the output register. Tags with their valid
// bits sit in one RAM per way and the LRU matrices in one RAM, each SETS deep,
// all read in the same cycle; a result written back in the cycle an address
// of the same set is read is forwarded, so back-to-back hits to one set cost
// nothing. After reset the block sweeps the memories clear, one set per cycle,
// holding in_stall high until every set is cleared; configuration writes are taken at
// any time but must only be made while no transaction is in flight.

module set_assoc_cache_matrix_lru import salru_pkg::*; #(
  parameter int WAYS      = WAYS_DEF,
  parameter int SETS      = SETS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADDR_W-1:0]     in_address,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [WAY_OUT_W-1:0]  out_way,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int LRU_W = WAYS * WAYS;

  // Configuration registers
  logic [OFFSET_W-1:0] offset_bits_r;
  logic [SETB_W-1:0]   idx_bits_r;
  logic [AWAYS_W-1:0]  active_ways_r;

  // Pipeline control
  logic s0_vld_r, s1_vld_r, out_vld_r;
  logic accept, s0_adv, commit;
  logic s1_free, s0_free;

  // Clearing sweep
  logic             clear_r;
  logic [SET_W-1:0] clr_cnt_r;

  // Datapath
  logic [SET_W-1:0]            s0_set;
  logic [TAG_W-1:0]            s0_tag;
  logic [SET_W-1:0]            s1_set_r;
  logic [TAG_W-1:0]            s1_tag_r;
  logic [WAYS-1:0][TAG_W:0]    tag_rd;
  logic [WAYS-1:0][TAG_W:0]    tag_eff;
  logic [LRU_W-1:0]            lru_rd;
  logic [LRU_W-1:0]            lru_eff;
  logic                        lk_hit;
  logic [WAY_W-1:0]            lk_way;
  logic [LRU_W-1:0]            lru_nxt;
  logic [WAY_W+WAY_OUT_W-1:0]  way_ext;
  logic                        out_hit_r;
  logic [WAY_OUT_W-1:0]        out_way_r;

  // Forwarding record of the write that raced the current set's read
  logic             fwd_vld_r;
  logic [SET_W-1:0] fwd_set_r;
  logic [WAY_W-1:0] fwd_way_r;
  logic [TAG_W-1:0] fwd_tag_r;
  logic [LRU_W-1:0] fwd_lru_r;
  logic             fwd_match;

  // Memory write port
  logic [SET_W-1:0] wr_addr;
  logic [TAG_W:0]   tag_wdata;
  logic [LRU_W-1:0] lru_wdata;

  // Handshake: each stage moves when the one after it frees up
  always_comb begin
    commit  = s1_vld_r && (!out_vld_r || !out_stall);
    s1_free = !s1_vld_r || commit;
    s0_adv  = s0_vld_r && s1_free;
    s0_free = !s0_vld_r || s0_adv;
    accept  = in_valid && !in_stall;
  end

  assign in_stall  = clear_r || !s0_free;
  assign cfg_ready = 1'b1;

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= OFFSET_BITS_RST;
      idx_bits_r    <= IDX_BITS_RST;
      active_ways_r <= ACTIVE_WAYS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_OFFSET_BITS: offset_bits_r <= OFFSET_W'(cfg_data);
        CFG_IDX_BITS:    idx_bits_r    <= SETB_W'(cfg_data);
        CFG_ACTIVE_WAYS: active_ways_r <= AWAYS_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Sweep every set clear after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r   <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clear_r) begin
      clr_cnt_r <= clr_cnt_r + SET_W'(1);
      if (clr_cnt_r == SET_W'(SETS - 1)) begin
        clear_r <= 1'b0;
      end
    end
  end

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        s0_vld_r <= 1'b1;
      end else if (s0_adv) begin
        s0_vld_r <= 1'b0;
      end
      if (s0_adv) begin
        s1_vld_r  <= 1'b1;
        fwd_vld_r <= commit;
      end else if (commit) begin
        s1_vld_r <= 1'b0;
      end
      if (commit) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Address split and input register
  salru_split #(
    .SETS      (SETS),
    .ADDR_BITS (ADDR_BITS)
  ) u_split (
    .clk         (clk),
    .ld          (accept),
    .address     (in_address),
    .offset_bits (offset_bits_r),
    .idx_bits    (idx_bits_r),
    .set_idx     (s0_set),
    .tag         (s0_tag)
  );

  // Memory write: clearing sweep or the committing transaction
  always_comb begin
    wr_addr   = clear_r ? clr_cnt_r : s1_set_r;
    tag_wdata = clear_r ? '0 : {1'b1, s1_tag_r};
    lru_wdata = clear_r ? '0 : lru_nxt;
  end

  // One tag RAM per way, read together
  generate
    for (genvar w = 0; w < WAYS; w++) begin : g_way
      salru_ram #(
        .WIDTH (TAG_W + 1),
        .DEPTH (SETS)
      ) u_tag_ram (
        .clk   (clk),
        .we    (clear_r || (commit && (lk_way == WAY_W'(w)))),
        .waddr (wr_addr),
        .wdata (tag_wdata),
        .re    (s0_adv),
        .raddr (s0_set),
        .rdata (tag_rd[w])
      );
    end
  endgenerate

  salru_ram #(
    .WIDTH (LRU_W),
    .DEPTH (SETS)
  ) u_lru_ram (
    .clk   (clk),
    .we    (clear_r || commit),
    .waddr (wr_addr),
    .wdata (lru_wdata),
    .re    (s0_adv),
    .raddr (s0_set),
    .rdata (lru_rd)
  );

  // Carry set and tag alongside the memory read
  always_ff @(posedge clk) begin
    if (s0_adv) begin
      s1_set_r  <= s0_set;
      s1_tag_r  <= s0_tag;
      fwd_set_r <= s1_set_r;
      fwd_way_r <= lk_way;
      fwd_tag_r <= s1_tag_r;
      fwd_lru_r <= lru_nxt;
    end
  end

  // Patch in the write that landed in the same cycle as the read
  always_comb begin
    fwd_match = fwd_vld_r && (fwd_set_r == s1_set_r);
    lru_eff   = fwd_match ? fwd_lru_r : lru_rd;
    for (int w = 0; w < WAYS; w++) begin
      if (fwd_match && (fwd_way_r == WAY_W'(w))) begin
        tag_eff[w] = {1'b1, fwd_tag_r};
      end else begin
        tag_eff[w] = tag_rd[w];
      end
    end
  end

  salru_lookup #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W)
  ) u_lookup (
    .active_ways (active_ways_r),
    .tag         (s1_tag_r),
    .tag_words   (tag_eff),
    .lru_word    (lru_eff),
    .hit         (lk_hit),
    .used_way    (lk_way),
    .lru_nxt     (lru_nxt)
  );

  // Result register
  assign way_ext = (WAY_W + WAY_OUT_W)'(lk_way);

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r <= lk_hit;
      out_way_r <= way_ext[WAY_OUT_W-1:0];
    end
  end

  assign out_valid = out_vld_r;
  assign out_hit   = out_hit_r;
  assign out_way   = out_way_r;

endmodule
